/* design/per_cpu_page_allocator_defines.svh */
// Assertion macros for the per-CPU page allocator.
`ifndef PER_CPU_PAGE_ALLOCATOR_DEFINES_SVH
`define PER_CPU_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PCPA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcpa assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define PCPA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcpa assertion failed");

`endif

/* design/pcpa_pkg.sv */
// Package for the per-CPU page allocator: payload types, codes and microprogram.
`default_nettype none

package pcpa_pkg;

  localparam int ADDR_W   = 40;
  localparam int CPU_W    = 3;
  localparam int STAT_W   = 2;
  localparam int STOLEN_W = 6;

  localparam int DEF_NUM_CPUS    = 8;
  localparam int DEF_NUM_PAGES   = 16384;
  localparam int DEF_STEAL_LIMIT = 50;

  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  localparam logic OP_ALLOC = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

  localparam int   CFG_IDX_W    = 1;
  localparam logic REG_RAM_BASE = 1'b0;
  localparam logic REG_RAM_STOP = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [CPU_W-1:0]  cpu;
    logic [ADDR_W-1:0] phys_addr;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [ADDR_W-1:0]   page_addr;
    logic [STOLEN_W-1:0] pages_stolen;
  } resp_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [2:0] {
    COND_TRUE,
    COND_IN_VALID,
    COND_HEAD_C,
    COND_ADDR_OK,
    COND_STEAL_DONE,
    COND_SKIP_V
  } cond_e;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_FIN_BAD,
    ACT_FIN_OOM,
    ACT_PUSH_FREE,
    ACT_RD_C,
    ACT_INC_V,
    ACT_LD_V,
    ACT_RD_V,
    ACT_MOVE,
    ACT_FIN_POP
  } act_e;

  typedef struct packed {
    cond_e cond;
    logic  disp;
    logic  hold;
    upc_t  jt;
    upc_t  jf;
    act_e  act_t;
    act_e  act_f;
  } ucw_t;

  // U_FREE must be even, U_ALLOC = U_FREE | 1 (op dispatch).
  localparam upc_t U_IDLE       = 4'd0;
  localparam upc_t U_POP_CHK    = 4'd1;
  localparam upc_t U_FREE       = 4'd2;
  localparam upc_t U_ALLOC      = 4'd3;
  localparam upc_t U_POP        = 4'd4;
  localparam upc_t U_STEAL_END  = 4'd5;
  localparam upc_t U_STEAL_SKIP = 4'd6;
  localparam upc_t U_STEAL_RD   = 4'd7;
  localparam upc_t U_STEAL_MOVE = 4'd8;

  function automatic ucw_t ucode(input upc_t a);
    ucw_t w;
    case (a)
      U_IDLE:       w = '{COND_IN_VALID, 1'b1, 1'b0, U_FREE, U_IDLE,
                          ACT_ACCEPT, ACT_NONE};
      U_POP_CHK:    w = '{COND_HEAD_C, 1'b0, 1'b1, U_POP, U_IDLE,
                          ACT_RD_C, ACT_FIN_OOM};
      U_FREE:       w = '{COND_ADDR_OK, 1'b0, 1'b1, U_IDLE, U_IDLE,
                          ACT_PUSH_FREE, ACT_FIN_BAD};
      U_ALLOC:      w = '{COND_HEAD_C, 1'b0, 1'b0, U_POP, U_STEAL_END,
                          ACT_RD_C, ACT_NONE};
      U_POP:        w = '{COND_TRUE, 1'b0, 1'b1, U_IDLE, U_IDLE,
                          ACT_FIN_POP, ACT_NONE};
      U_STEAL_END:  w = '{COND_STEAL_DONE, 1'b0, 1'b0, U_POP_CHK, U_STEAL_SKIP,
                          ACT_NONE, ACT_NONE};
      U_STEAL_SKIP: w = '{COND_SKIP_V, 1'b0, 1'b0, U_STEAL_END, U_STEAL_RD,
                          ACT_INC_V, ACT_LD_V};
      U_STEAL_RD:   w = '{COND_TRUE, 1'b0, 1'b0, U_STEAL_MOVE, U_STEAL_MOVE,
                          ACT_RD_V, ACT_NONE};
      U_STEAL_MOVE: w = '{COND_TRUE, 1'b0, 1'b0, U_STEAL_END, U_STEAL_END,
                          ACT_MOVE, ACT_NONE};
      default:      w = '{COND_TRUE, 1'b0, 1'b0, U_IDLE, U_IDLE,
                          ACT_NONE, ACT_NONE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* design/per_cpu_page_allocator.sv */
// Per-CPU page allocator: microcoded sequencer, head registers and link table.
`default_nettype none
`include "per_cpu_page_allocator_defines.svh"

// Page allocator with one LIFO free list per CPU, run by a small microprogram
// over a single-port link table. A free checks the address and pushes the
// page; an allocate served from the CPU's own list reads its head and pops it.
// An allocate that finds its own list empty visits the other lists in turn,
// skipping its own and empty ones, and steals pages onto its own list (at most
// STEAL_LIMIT) before it pops or reports out of memory; each moved page takes a
// link table read and then a write. A finishing step holds while an earlier
// result still waits at the output. The link table is not cleared after reset;
// entries are always written before they are followed. Page size is fixed at
// PAGE_BYTES from the package.
module per_cpu_page_allocator
  import pcpa_pkg::*;
#(
  parameter int NUM_CPUS    = DEF_NUM_CPUS,
  parameter int NUM_PAGES   = DEF_NUM_PAGES,
  parameter int STEAL_LIMIT = DEF_STEAL_LIMIT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire req_t                 in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output resp_t                     out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data
);

  localparam int PW   = $clog2(NUM_PAGES);
  localparam int CIW  = $clog2(NUM_CPUS);
  localparam int VW   = $clog2(NUM_CPUS + 1);
  localparam int CNTW = $clog2(STEAL_LIMIT + 1);
  localparam int SW   = (CNTW > STOLEN_W) ? CNTW : STOLEN_W;
  localparam int PGW  = ADDR_W - PAGE_SHIFT;

  upc_t              pc;
  upc_t              pc_next;
  ucw_t              cw;
  logic              cond;
  logic              stall;
  act_e              act;
  logic              fin;

  logic [ADDR_W-1:0] ram_base;
  logic [ADDR_W-1:0] ram_stop;

  logic [CPU_W-1:0]  cpu_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PW-1:0]     chead;
  logic              chvalid;
  logic [VW-1:0]     v;
  logic [PW-1:0]     vhead;
  logic [CNTW-1:0]   count;

  logic [PW-1:0]     head_rf [NUM_CPUS];
  logic [NUM_CPUS-1:0] hvalid;
  logic [PW:0]       mem [NUM_PAGES];
  logic [PW:0]       rd_q;

  logic [CIW-1:0]    cpu_idx;
  logic [CIW-1:0]    in_cpu_idx;
  logic [CIW-1:0]    v_idx;
  logic              cpu_ok;
  logic              in_cpu_ok;
  logic [ADDR_W-1:0] off;
  logic [PGW-1:0]    off_pg;
  logic [PW-1:0]     free_idx;
  logic              addr_ok;
  logic              steal_done;
  logic              skip_v;
  logic [ADDR_W-1:0] page_out;
  logic [SW-1:0]     stolen_ext;

  logic              mem_we;
  logic [PW-1:0]     mem_waddr;
  logic              mem_re;
  logic [PW-1:0]     mem_raddr;

  assign cpu_idx    = CIW'(cpu_r);
  assign in_cpu_idx = CIW'(in_data.cpu);
  assign v_idx      = v[CIW-1:0];
  assign cpu_ok     = int'(cpu_r) < NUM_CPUS;
  assign in_cpu_ok  = int'(in_data.cpu) < NUM_CPUS;

  assign off      = addr_r - ram_base;
  assign off_pg   = off[ADDR_W-1:PAGE_SHIFT];
  assign free_idx = off_pg[PW-1:0];
  assign addr_ok  = cpu_ok && (addr_r[PAGE_SHIFT-1:0] == '0) && (addr_r >= ram_base) &&
                    (addr_r < ram_stop) && (off[PAGE_SHIFT-1:0] == '0) &&
                    (off_pg < PGW'(NUM_PAGES));

  assign steal_done = (v == VW'(NUM_CPUS)) || (count == CNTW'(STEAL_LIMIT)) || !cpu_ok;
  assign skip_v     = (v_idx == cpu_idx) || !hvalid[v_idx];
  assign page_out   = ram_base + (ADDR_W'(chead) << PAGE_SHIFT);
  assign stolen_ext = SW'(count);

  // sequencer
  assign cw    = ucode(pc);
  assign stall = cw.hold && out_valid && !out_ready;

  always_comb begin
    case (cw.cond)
      COND_TRUE:       cond = 1'b1;
      COND_IN_VALID:   cond = in_valid;
      COND_HEAD_C:     cond = cpu_ok && chvalid;
      COND_ADDR_OK:    cond = addr_ok;
      COND_STEAL_DONE: cond = steal_done;
      COND_SKIP_V:     cond = skip_v;
      default:         cond = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      act     = ACT_NONE;
      pc_next = pc;
    end else if (cond) begin
      act     = cw.act_t;
      pc_next = cw.disp ? (cw.jt | UPC_W'(in_data.operation == OP_ALLOC)) : cw.jt;
    end else begin
      act     = cw.act_f;
      pc_next = cw.jf;
    end
  end

  assign fin       = (act == ACT_FIN_BAD) || (act == ACT_FIN_OOM) ||
                     (act == ACT_PUSH_FREE) || (act == ACT_FIN_POP);
  assign in_ready  = (pc == U_IDLE);
  assign cfg_ready = 1'b1;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= U_IDLE;
      out_valid <= 1'b0;
      v         <= '0;
      count     <= '0;
      chvalid   <= 1'b0;
      ram_base  <= '0;
      ram_stop  <= '0;
    end else begin
      pc <= pc_next;
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (act)
        ACT_ACCEPT: begin
          v       <= '0;
          count   <= '0;
          chvalid <= in_cpu_ok && hvalid[in_cpu_idx];
        end
        ACT_INC_V: v <= v + VW'(1);
        ACT_MOVE: begin
          count   <= count + CNTW'(1);
          chvalid <= 1'b1;
        end
        default: ;
      endcase
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RAM_BASE: ram_base <= cfg_data;
          REG_RAM_STOP: ram_stop <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // list valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid <= '0;
    end else begin
      case (act)
        ACT_PUSH_FREE: hvalid[cpu_idx] <= 1'b1;
        ACT_MOVE:      hvalid[v_idx]   <= rd_q[PW];
        ACT_FIN_POP:   hvalid[cpu_idx] <= rd_q[PW];
        default: ;
      endcase
    end
  end

  // request payload, head registers and cached heads
  always_ff @(posedge clk) begin
    case (act)
      ACT_ACCEPT: begin
        cpu_r  <= in_data.cpu;
        addr_r <= in_data.phys_addr;
        chead  <= head_rf[in_cpu_idx];
      end
      ACT_PUSH_FREE: head_rf[cpu_idx] <= free_idx;
      ACT_LD_V:      vhead <= head_rf[v_idx];
      ACT_MOVE: begin
        head_rf[v_idx] <= rd_q[PW-1:0];
        chead          <= vhead;
      end
      ACT_FIN_POP:   head_rf[cpu_idx] <= rd_q[PW-1:0];
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    case (act)
      ACT_FIN_BAD:   out_data <= '{ST_BAD, '0, '0};
      ACT_FIN_OOM:   out_data <= '{ST_OOM, '0, '0};
      ACT_PUSH_FREE: out_data <= '{ST_OK, '0, '0};
      ACT_FIN_POP:   out_data <= '{ST_OK, page_out, stolen_ext[STOLEN_W-1:0]};
      default: ;
    endcase
  end

  // link table, one access per cycle
  assign mem_we    = (act == ACT_PUSH_FREE) || (act == ACT_MOVE);
  assign mem_waddr = (act == ACT_MOVE) ? vhead : free_idx;
  assign mem_re    = (act == ACT_RD_C) || (act == ACT_RD_V);
  assign mem_raddr = (act == ACT_RD_V) ? vhead : chead;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= {chvalid, chead};
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  `PCPA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, pc != U_IDLE)
  `PCPA_ASSERT_IMPL(a_fin_slot_free, fin, !out_valid || out_ready)
  `PCPA_ASSERT_IMPL(a_stolen_only_ok, out_valid && (out_data.pages_stolen != '0), out_data.status == ST_OK)
  `PCPA_ASSERT_IMPL(a_count_limit, pc != U_IDLE, count <= CNTW'(STEAL_LIMIT))

endmodule

`default_nettype wire
